FILE: hdl/scan_point_map_occupancy_filter_core_assert.svh
// Assertion macros for the checker file of the occupancy filter core
`ifndef SCAN_POINT_MAP_OCCUPANCY_FILTER_CORE_ASSERT_SVH
`define SCAN_POINT_MAP_OCCUPANCY_FILTER_CORE_ASSERT_SVH

// Same-cycle implication, off while reset is asserted
`define SPMOF_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("spmof assertion failed");

// Next-cycle implication, off while reset is asserted
`define SPMOF_ASSERT_NXT_RST(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("spmof assertion failed");

// Next-cycle implication that also holds through reset
`define SPMOF_ASSERT_NXT(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("spmof assertion failed");

`endif

FILE: hdl/spmof_pkg.sv
// Package: constants, codes and shared types of the occupancy filter core
`timescale 1ns / 1ps
package spmof_pkg;

    localparam int MAP_CELLS  = 1048576;
    localparam int MAX_OFFSET = 15;
    localparam int MAX_BEAMS  = 4096;

    localparam int MAP_AW    = $clog2(MAP_CELLS);
    localparam int WORD_AW   = MAP_AW - 5;
    localparam int MAP_WORDS = (MAP_CELLS + 31) / 32;
    localparam int BEAM_W    = $clog2(MAX_BEAMS);
    localparam int K_W       = $clog2(MAX_OFFSET + 2);
    localparam int LIM_W     = 25;
    localparam int FLAT_W    = 44;

    localparam logic signed [7:0] OCC_VALUE = 8'sd100;
    localparam int Q14_ONE = 16384;
    localparam int POLY_C3 = 2320;
    localparam int POLY_C5 = 21024;
    localparam int POLY_PI = 51472;

    // Input actions
    localparam logic [1:0] ACT_CELL   = 2'd0;
    localparam logic [1:0] ACT_SCAN   = 2'd1;
    localparam logic [1:0] ACT_BEAM   = 2'd2;
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    // Configuration register indexes
    localparam logic [2:0] CFG_MAX_RANGE = 3'd0;
    localparam logic [2:0] CFG_OFFSET    = 3'd1;
    localparam logic [2:0] CFG_SCALE     = 3'd2;
    localparam logic [2:0] CFG_ORIGIN_X  = 3'd3;
    localparam logic [2:0] CFG_ORIGIN_Y  = 3'd4;
    localparam logic [2:0] CFG_MAP_W     = 3'd5;
    localparam logic [2:0] CFG_MAP_H     = 3'd6;

    typedef struct packed {
        logic signed [23:0] pose_x;
        logic signed [23:0] pose_y;
        logic signed [15:0] cos_q14;
        logic signed [15:0] sin_q14;
        logic [15:0]        ang_start;
        logic [15:0]        ang_step;
    } t_scan;

    typedef struct packed {
        logic                     wr;
        logic                     walk;
        logic [MAP_AW-1:0]        cell_addr;
        logic                     occ;
        logic signed [FLAT_W-1:0] flat;
        logic [K_W-1:0]           k;
        logic [10:0]              w;
        logic [10:0]              h;
    } t_map_cmd;

    typedef struct packed {
        logic busy;
        logic done;
        logic hit;
    } t_map_stat;

    typedef struct packed {
        logic                     done;
        logic signed [FLAT_W-1:0] flat;
    } t_geom_res;

endpackage

FILE: hdl/spmof_in_if.sv
// Input channel: valid/ready plus the fields of one input beat
`timescale 1ns / 1ps
interface spmof_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         action;
    logic [19:0]        cell_index;
    logic signed [7:0]  cell_value;
    logic [15:0]        range_mm;
    logic signed [23:0] pose_x_mm;
    logic signed [23:0] pose_y_mm;
    logic signed [15:0] pose_cos;
    logic signed [15:0] pose_sin;
    logic signed [15:0] angle_start;
    logic signed [15:0] angle_step;

    modport source (output valid, action, cell_index, cell_value, range_mm, pose_x_mm,
                    pose_y_mm, pose_cos, pose_sin, angle_start, angle_step, input ready);
    modport sink (input valid, action, cell_index, cell_value, range_mm, pose_x_mm,
                  pose_y_mm, pose_cos, pose_sin, angle_start, angle_step, output ready);
endinterface

FILE: hdl/spmof_out_if.sv
// Output channel: valid/ready plus the fields of one result beat
`timescale 1ns / 1ps
interface spmof_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] filtered_range_mm;
    logic        removed;
    logic [11:0] beam_number;

    modport source (output valid, filtered_range_mm, removed, beam_number, input ready);
    modport sink (input valid, filtered_range_mm, removed, beam_number, output ready);
endinterface

FILE: hdl/spmof_geom.sv
// Beam geometry sequencer: beam angle, sine/cosine, rotation, flat cell index
`timescale 1ns / 1ps
module spmof_geom (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic [15:0]            i_range,
    input  logic [spmof_pkg::BEAM_W-1:0] i_beam,
    input  spmof_pkg::t_scan       i_scan,
    input  logic [20:0]            i_scale,
    input  logic signed [23:0]     i_org_x,
    input  logic signed [23:0]     i_org_y,
    input  logic [10:0]            i_width,
    output spmof_pkg::t_geom_res   o_res
);
    import spmof_pkg::*;

    localparam logic [4:0] G_IDLE = 5'd0;
    localparam logic [4:0] G_ANG  = 5'd1;
    localparam logic [4:0] G_Z    = 5'd2;
    localparam logic [4:0] G_T    = 5'd3;
    localparam logic [4:0] G_V    = 5'd4;
    localparam logic [4:0] G_S    = 5'd5;
    localparam logic [4:0] G_PX   = 5'd6;
    localparam logic [4:0] G_PY   = 5'd7;
    localparam logic [4:0] G_M1   = 5'd8;
    localparam logic [4:0] G_M2   = 5'd9;
    localparam logic [4:0] G_M3   = 5'd10;
    localparam logic [4:0] G_M4   = 5'd11;
    localparam logic [4:0] G_M5   = 5'd12;
    localparam logic [4:0] G_Q    = 5'd13;
    localparam logic [4:0] G_CX   = 5'd14;
    localparam logic [4:0] G_CY   = 5'd15;
    localparam logic [4:0] G_CYD  = 5'd16;
    localparam logic [4:0] G_IW   = 5'd17;
    localparam logic [4:0] G_FLAT = 5'd18;

    // Signed divide by 2^20 / 2^28, truncating toward zero
    function automatic logic signed [30:0] tdiv20(input logic signed [50:0] v);
        logic signed [50:0] b;
        b = v + (v[50] ? 51'sd1048575 : 51'sd0);
        return b[50:20];
    endfunction

    function automatic logic signed [28:0] tdiv28(input logic signed [56:0] v);
        logic signed [56:0] b;
        b = v + (v[56] ? 57'sd268435455 : 57'sd0);
        return b[56:28];
    endfunction

    logic [4:0]               r_state;
    logic                     r_pass;
    logic                     r_done;
    logic [15:0]              r_a;
    logic [14:0]              r_z;
    logic                     r_neg;
    logic [14:0]              r_z2;
    logic [11:0]              r_t;
    logic [14:0]              r_v;
    logic signed [16:0]       r_sb;
    logic signed [16:0]       r_cb;
    logic signed [33:0]       r_px;
    logic signed [33:0]       r_py;
    logic signed [49:0]       r_m1;
    logic signed [49:0]       r_m2;
    logic signed [50:0]       r_rx;
    logic signed [50:0]       r_ry;
    logic signed [34:0]       r_qx;
    logic signed [34:0]       r_qy;
    logic signed [56:0]       r_pm;
    logic signed [28:0]       r_ix;
    logic signed [28:0]       r_iy;
    logic signed [40:0]       r_iw;
    logic signed [FLAT_W-1:0] r_flat;

    logic [BEAM_W+15:0] w_aprod;
    logic [15:0]        w_ang;
    logic [14:0]        w_p;
    logic [14:0]        w_zf;
    logic [29:0]        w_zz;
    logic [25:0]        w_tp;
    logic [29:0]        w_vp;
    logic [30:0]        w_sp;
    logic [16:0]        w_smag;
    logic signed [24:0] w_dx;
    logic signed [24:0] w_dy;

    // Quarter-wave polynomial datapath, one multiply per step
    always_comb begin
        w_aprod = i_beam * i_scan.ang_step;
        w_ang   = r_pass ? (r_a + 16'(Q14_ONE)) : r_a;
        w_p     = {1'b0, w_ang[13:0]};
        w_zf    = w_ang[14] ? (15'(Q14_ONE) - w_p) : w_p;
        w_zz    = {15'd0, w_zf} * {15'd0, w_zf};
        w_tp    = 26'(POLY_C3) * {11'd0, r_z2};
        w_vp    = {15'd0, r_z2} * {15'd0, 15'(POLY_C5) - {3'd0, r_t}};
        w_sp    = {16'd0, r_z} * (16'(POLY_PI) - {1'b0, r_v});
        w_smag  = {1'b0, w_sp[30:15]};
        w_dx    = {i_scan.pose_x[23], i_scan.pose_x} - {i_org_x[23], i_org_x};
        w_dy    = {i_scan.pose_y[23], i_scan.pose_y} - {i_org_y[23], i_org_y};
    end

    // Sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= G_IDLE;
            r_pass  <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                G_IDLE: if (i_start) r_state <= G_ANG;
                G_ANG:  begin
                    r_pass  <= 1'b0;
                    r_state <= G_Z;
                end
                G_Z:    r_state <= G_T;
                G_T:    r_state <= G_V;
                G_V:    r_state <= G_S;
                G_S:    begin
                    r_pass  <= 1'b1;
                    r_state <= r_pass ? G_PX : G_Z;
                end
                G_PX:   r_state <= G_PY;
                G_PY:   r_state <= G_M1;
                G_M1:   r_state <= G_M2;
                G_M2:   r_state <= G_M3;
                G_M3:   r_state <= G_M4;
                G_M4:   r_state <= G_M5;
                G_M5:   r_state <= G_Q;
                G_Q:    r_state <= G_CX;
                G_CX:   r_state <= G_CY;
                G_CY:   r_state <= G_CYD;
                G_CYD:  r_state <= G_IW;
                G_IW:   r_state <= G_FLAT;
                G_FLAT: begin
                    r_done  <= 1'b1;
                    r_state <= G_IDLE;
                end
                default: r_state <= G_IDLE;
            endcase
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            G_ANG: r_a <= i_scan.ang_start + w_aprod[15:0];
            G_Z: begin
                r_z   <= w_zf;
                r_neg <= w_ang[15];
                r_z2  <= w_zz[28:14];
            end
            G_T: r_t <= w_tp[25:14];
            G_V: r_v <= w_vp[28:14];
            G_S: begin
                if (r_pass) r_cb <= r_neg ? -$signed(w_smag) : $signed(w_smag);
                else        r_sb <= r_neg ? -$signed(w_smag) : $signed(w_smag);
            end
            G_PX: r_px <= $signed({1'b0, i_range}) * r_cb;
            G_PY: r_py <= $signed({1'b0, i_range}) * r_sb;
            G_M1: r_m1 <= i_scan.cos_q14 * r_px;
            G_M2: r_m2 <= i_scan.sin_q14 * r_py;
            G_M3: begin
                r_rx <= 51'(r_m1) - 51'(r_m2);
                r_m1 <= i_scan.sin_q14 * r_px;
            end
            G_M4: r_m2 <= i_scan.cos_q14 * r_py;
            G_M5: r_ry <= 51'(r_m1) + 51'(r_m2);
            G_Q: begin
                r_qx <= 35'(tdiv20(r_rx)) + 35'($signed({w_dx, 8'd0}));
                r_qy <= 35'(tdiv20(r_ry)) + 35'($signed({w_dy, 8'd0}));
            end
            G_CX: r_pm <= r_qx * $signed({1'b0, i_scale});
            G_CY: begin
                r_ix <= tdiv28(r_pm);
                r_pm <= r_qy * $signed({1'b0, i_scale});
            end
            G_CYD: r_iy <= tdiv28(r_pm);
            G_IW: r_iw <= r_iy * $signed({1'b0, i_width});
            G_FLAT: r_flat <= FLAT_W'(r_ix) + FLAT_W'(r_iw);
            default: ;
        endcase
    end

    assign o_res.done = r_done;
    assign o_res.flat = r_flat;
endmodule

FILE: hdl/spmof_map.sv
// Occupancy map: bit memory, clearing pass, cell read-modify-write, neighborhood walk
`timescale 1ns / 1ps
module spmof_map (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  spmof_pkg::t_map_cmd  i_cmd,
    output spmof_pkg::t_map_stat o_stat
);
    import spmof_pkg::*;

    localparam logic [2:0] M_CLR   = 3'd0;
    localparam logic [2:0] M_IDLE  = 3'd1;
    localparam logic [2:0] M_WMOD  = 3'd2;
    localparam logic [2:0] M_WALK  = 3'd3;
    localparam logic [2:0] M_DRAIN = 3'd4;

    logic [31:0] r_mem [MAP_WORDS];
    logic [31:0] r_rd_data;

    logic [2:0]               r_state;
    logic [WORD_AW-1:0]       r_clr_addr;
    logic [WORD_AW-1:0]       r_waddr;
    logic [4:0]               r_wbit;
    logic                     r_occ;
    logic                     r_done;
    logic                     r_hit;
    logic signed [FLAT_W-1:0] r_row;
    logic signed [FLAT_W-1:0] r_tgt;
    logic [K_W:0]             r_dx;
    logic [K_W:0]             r_dy;
    logic [K_W:0]             r_span;
    logic [LIM_W-1:0]         r_lim;
    logic                     r_pend;
    logic [4:0]               r_pbit;

    logic                     w_we;
    logic [WORD_AW-1:0]       w_wa;
    logic [31:0]              w_wd;
    logic [WORD_AW-1:0]       w_ra;
    logic                     w_valid;
    logic                     w_bit;
    logic [K_W+10:0]          w_kw;
    logic [21:0]              w_wh;
    logic [FLAT_W-1:0]        w_next_row;

    // Port muxing and walk checks
    always_comb begin
        w_kw       = i_cmd.k * i_cmd.w;
        w_wh       = i_cmd.w * i_cmd.h;
        w_valid    = !r_tgt[FLAT_W-1] && (r_tgt < $signed(FLAT_W'(r_lim)));
        w_bit      = r_rd_data[r_pbit];
        w_next_row = r_row + FLAT_W'(r_span - r_span + {1'b0, K_W'(0)}) + FLAT_W'(i_cmd.w);
        w_we = 1'b0;
        w_wa = r_waddr;
        w_wd = r_rd_data;
        w_ra = i_cmd.cell_addr[MAP_AW-1:5];
        unique case (r_state)
            M_CLR: begin
                w_we = 1'b1;
                w_wa = r_clr_addr;
                w_wd = '0;
            end
            M_WMOD: begin
                w_we         = 1'b1;
                w_wd[r_wbit] = r_occ;
            end
            M_WALK:  w_ra = r_tgt[MAP_AW-1:5];
            default: ;
        endcase
    end

    // Bit memory, 32 cells a word, registered read
    always_ff @(posedge i_clk) begin
        if (w_we) r_mem[w_wa] <= w_wd;
        r_rd_data <= r_mem[w_ra];
    end

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= M_CLR;
            r_clr_addr <= '0;
            r_done     <= 1'b0;
            r_hit      <= 1'b0;
            r_pend     <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                M_CLR: begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                    if (r_clr_addr == WORD_AW'(MAP_WORDS - 1)) r_state <= M_IDLE;
                end
                M_IDLE: begin
                    if (i_cmd.wr) begin
                        r_waddr <= i_cmd.cell_addr[MAP_AW-1:5];
                        r_wbit  <= i_cmd.cell_addr[4:0];
                        r_occ   <= i_cmd.occ;
                        r_state <= M_WMOD;
                    end else if (i_cmd.walk) begin
                        r_row   <= i_cmd.flat - FLAT_W'(i_cmd.k) - FLAT_W'(w_kw);
                        r_tgt   <= i_cmd.flat - FLAT_W'(i_cmd.k) - FLAT_W'(w_kw);
                        r_dx    <= '0;
                        r_dy    <= '0;
                        r_span  <= {i_cmd.k, 1'b0};
                        r_lim   <= (LIM_W'(w_wh) < LIM_W'(MAP_CELLS)) ?
                                   LIM_W'(w_wh) : LIM_W'(MAP_CELLS);
                        r_pend  <= 1'b0;
                        r_state <= M_WALK;
                    end
                end
                M_WMOD: begin
                    r_done  <= 1'b1;
                    r_state <= M_IDLE;
                end
                M_WALK: begin
                    r_pend <= w_valid;
                    r_pbit <= r_tgt[4:0];
                    if (r_pend && w_bit) begin
                        r_hit   <= 1'b1;
                        r_done  <= 1'b1;
                        r_state <= M_IDLE;
                    end else if (r_dx == r_span) begin
                        if (r_dy == r_span) begin
                            r_state <= M_DRAIN;
                        end else begin
                            r_dx  <= '0;
                            r_dy  <= r_dy + 1'b1;
                            r_row <= w_next_row;
                            r_tgt <= w_next_row;
                        end
                    end else begin
                        r_dx  <= r_dx + 1'b1;
                        r_tgt <= r_tgt + FLAT_W'(1);
                    end
                end
                M_DRAIN: begin
                    r_hit   <= r_pend && w_bit;
                    r_done  <= 1'b1;
                    r_state <= M_IDLE;
                end
                default: r_state <= M_IDLE;
            endcase
        end
    end

    assign o_stat.busy = (r_state == M_CLR);
    assign o_stat.done = r_done;
    assign o_stat.hit  = r_hit;
endmodule

FILE: hdl/scan_point_map_occupancy_filter_core.sv
// Top level: configuration, scan state, beat control and result register
//
// Input channel i_in takes one beat per action: a map cell write, a scan start that
// latches the sensor pose and beam angles and zeroes the beam counter, or a beam
// sample. Only beam samples give a result beat on o_out; other actions give none.
// Configuration registers are written through i_cfg_wr_en / i_cfg_index /
// i_cfg_wdata; the user must write them only while no beat is in flight, as the
// block itself does not enforce it. Items are handled one at a time. A cell write
// reads, modifies and writes back the 32-cell map word. A beam sample over the
// maximum range goes straight to the result register; otherwise the geometry
// sequencer runs 22 steps and the neighborhood walk then reads one map cell a
// cycle through the single map read port over (2k+1)^2 cells, k the configured
// offset, stopping at the first occupied one.
// After reset the map is cleared one 32-cell word a cycle, during which
// i_in.ready stays low. The result sits in an output register; while the
// receiver stalls it holds, and new beats are still taken until the next result
// has to wait for that register.
`timescale 1ns / 1ps
module scan_point_map_occupancy_filter_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [2:0]  i_cfg_index,
    input  logic [23:0] i_cfg_wdata,
    spmof_in_if.sink    i_in,
    spmof_out_if.source o_out
);
    import spmof_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MAPW = 3'd1;
    localparam logic [2:0] ST_GEOM = 3'd2;
    localparam logic [2:0] ST_WALK = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;

    // Configuration registers
    logic [15:0]        r_max_range;
    logic [3:0]         r_offset;
    logic [20:0]        r_scale;
    logic signed [23:0] r_org_x;
    logic signed [23:0] r_org_y;
    logic [10:0]        r_map_w;
    logic [10:0]        r_map_h;

    logic [2:0]          r_state;
    t_scan               r_scan;
    logic [BEAM_W-1:0]   r_beam_cnt;
    logic [BEAM_W-1:0]   r_beam;
    logic [15:0]         r_range;
    logic                r_rm;
    logic                r_geom_go;
    logic                r_map_wr;
    logic                r_map_walk;
    logic [MAP_AW-1:0]   r_cell;
    logic                r_occ;
    logic                r_out_valid;
    logic [15:0]         r_out_range;
    logic                r_out_removed;
    logic [11:0]         r_out_beam;

    logic       w_accept;
    logic [K_W-1:0] w_k;
    t_map_cmd   w_mcmd;
    t_map_stat  w_mstat;
    t_geom_res  w_geom;

    assign i_in.ready = (r_state == ST_IDLE) && !w_mstat.busy;
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_k        = (32'(r_offset) > MAX_OFFSET) ? K_W'(MAX_OFFSET) : K_W'(r_offset);

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_range <= 16'd5000;
            r_offset    <= 4'd3;
            r_scale     <= 21'd20972;
            r_org_x     <= '0;
            r_org_y     <= '0;
            r_map_w     <= 11'd1024;
            r_map_h     <= 11'd1024;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_MAX_RANGE: r_max_range <= i_cfg_wdata[15:0];
                CFG_OFFSET:    r_offset    <= i_cfg_wdata[3:0];
                CFG_SCALE:     r_scale     <= i_cfg_wdata[20:0];
                CFG_ORIGIN_X:  r_org_x     <= $signed(i_cfg_wdata);
                CFG_ORIGIN_Y:  r_org_y     <= $signed(i_cfg_wdata);
                CFG_MAP_W:     r_map_w     <= i_cfg_wdata[10:0];
                CFG_MAP_H:     r_map_h     <= i_cfg_wdata[10:0];
                default: ;
            endcase
        end
    end

    // Beat control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_beam_cnt     <= '0;
            r_scan.pose_x  <= '0;
            r_scan.pose_y  <= '0;
            r_scan.cos_q14 <= 16'sd16384;
            r_scan.sin_q14 <= '0;
            r_scan.ang_start <= '0;
            r_scan.ang_step  <= '0;
            r_geom_go      <= 1'b0;
            r_map_wr       <= 1'b0;
            r_map_walk     <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            r_geom_go  <= 1'b0;
            r_map_wr   <= 1'b0;
            r_map_walk <= 1'b0;
            if (o_out.ready) r_out_valid <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        case (i_in.action)
                            ACT_CELL: begin
                                if ({5'd0, i_in.cell_index} < LIM_W'(MAP_CELLS)) begin
                                    r_cell   <= MAP_AW'(i_in.cell_index);
                                    r_occ    <= (i_in.cell_value == OCC_VALUE);
                                    r_map_wr <= 1'b1;
                                    r_state  <= ST_MAPW;
                                end
                            end
                            ACT_SCAN: begin
                                r_scan.pose_x    <= i_in.pose_x_mm;
                                r_scan.pose_y    <= i_in.pose_y_mm;
                                r_scan.cos_q14   <= i_in.pose_cos;
                                r_scan.sin_q14   <= i_in.pose_sin;
                                r_scan.ang_start <= i_in.angle_start;
                                r_scan.ang_step  <= i_in.angle_step;
                                r_beam_cnt       <= '0;
                            end
                            ACT_BEAM: begin
                                r_range <= i_in.range_mm;
                                r_beam  <= r_beam_cnt;
                                r_beam_cnt <= (r_beam_cnt == BEAM_W'(MAX_BEAMS - 1)) ?
                                              '0 : r_beam_cnt + 1'b1;
                                if (i_in.range_mm > r_max_range) begin
                                    r_rm    <= 1'b1;
                                    r_state <= ST_OUT;
                                end else begin
                                    r_geom_go <= 1'b1;
                                    r_state   <= ST_GEOM;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                ST_MAPW: if (w_mstat.done) r_state <= ST_IDLE;
                ST_GEOM: begin
                    if (w_geom.done) begin
                        r_map_walk <= 1'b1;
                        r_state    <= ST_WALK;
                    end
                end
                ST_WALK: begin
                    if (w_mstat.done) begin
                        r_rm    <= w_mstat.hit;
                        r_state <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (!r_out_valid || o_out.ready) begin
                        r_out_valid <= 1'b1;
                        r_state     <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (r_state == ST_OUT && (!r_out_valid || o_out.ready)) begin
            r_out_range   <= r_rm ? 16'd0 : r_range;
            r_out_removed <= r_rm;
            r_out_beam    <= 12'(r_beam);
        end
    end

    assign w_mcmd.wr        = r_map_wr;
    assign w_mcmd.walk      = r_map_walk;
    assign w_mcmd.cell_addr = r_cell;
    assign w_mcmd.occ       = r_occ;
    assign w_mcmd.flat      = w_geom.flat;
    assign w_mcmd.k         = w_k;
    assign w_mcmd.w         = r_map_w;
    assign w_mcmd.h         = r_map_h;

    spmof_geom u_geom (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_geom_go),
        .i_range (r_range),
        .i_beam  (r_beam),
        .i_scan  (r_scan),
        .i_scale (r_scale),
        .i_org_x (r_org_x),
        .i_org_y (r_org_y),
        .i_width (r_map_w),
        .o_res   (w_geom)
    );

    spmof_map u_map (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_mcmd),
        .o_stat  (w_mstat)
    );

    assign o_out.valid             = r_out_valid;
    assign o_out.filtered_range_mm = r_out_range;
    assign o_out.removed           = r_out_removed;
    assign o_out.beam_number       = r_out_beam;
endmodule

FILE: hdl/spmof_chk.sv
// Port checker for the occupancy filter core, bound to the top level
`timescale 1ns / 1ps
`include "scan_point_map_occupancy_filter_core_assert.svh"
module spmof_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [15:0] i_out_range,
    input logic        i_out_removed,
    input logic [11:0] i_out_beam
);
    // Map clearing starts at reset, so no beat is taken right after it
    `SPMOF_ASSERT_NXT(a_rst_not_ready, i_clk, !i_rst_n, !i_in_ready)
    // Result register is empty after reset
    `SPMOF_ASSERT_NXT(a_rst_no_out, i_clk, !i_rst_n, !i_out_valid)
    // A stalled result holds
    `SPMOF_ASSERT_NXT_RST(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_range) && $stable(i_out_beam) && $stable(i_out_removed))
    // A removed beam reports range zero
    `SPMOF_ASSERT_IMP(a_removed_zero, i_clk, i_rst_n, i_out_valid && i_out_removed, i_out_range == 16'd0)
endmodule

bind scan_point_map_occupancy_filter_core spmof_chk u_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_ready    (i_in.ready),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_out_range   (o_out.filtered_range_mm),
    .i_out_removed (o_out.removed),
    .i_out_beam    (o_out.beam_number)
);

FILE: tb/sv/tb_scan_point_map_occupancy_filter_core.sv
// Testbench: directed, random and backpressure tests of the occupancy filter core
`timescale 1ns / 1ps
module tb_scan_point_map_occupancy_filter_core;
    import spmof_pkg::*;

    localparam longint CYCLE_LIMIT = 4000000;

    typedef struct {
        logic [1:0]         action;
        logic [19:0]        cell_index;
        logic signed [7:0]  cell_value;
        logic [15:0]        range_mm;
        logic signed [23:0] pose_x_mm;
        logic signed [23:0] pose_y_mm;
        logic signed [15:0] pose_cos;
        logic signed [15:0] pose_sin;
        logic signed [15:0] angle_start;
        logic signed [15:0] angle_step;
    } t_beam_item;

    typedef struct {
        logic [15:0] range_mm;
        logic        removed;
        logic [11:0] beam;
    } t_beam_result;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_wr_en;
    logic [2:0]  i_cfg_index;
    logic [23:0] i_cfg_wdata;

    spmof_in_if  in_if ();
    spmof_out_if out_if ();

    scan_point_map_occupancy_filter_core uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (in_if),
        .o_out       (out_if)
    );

    // Predictor state: map, scan pose and configuration
    bit                 occ_map [MAP_CELLS];
    logic [11:0]        beam_cnt;
    logic signed [23:0] scan_x, scan_y;
    logic signed [15:0] scan_c, scan_s;
    logic [15:0]        scan_a0, scan_da;
    logic [15:0]        cfg_max_range;
    logic [3:0]         cfg_offset;
    logic [20:0]        cfg_scale;
    logic signed [23:0] cfg_org_x, cfg_org_y;
    logic [10:0]        cfg_w, cfg_h;

    t_beam_result pending_results[$];
    int           errors;
    longint       cycles;
    int           burst_left;
    bit           no_gaps;
    int           hold_req;

    // Clock and cycle watchdog
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_scan_point_map_occupancy_filter_core NOT OK");
            $finish;
        end
    end

    // Fixed point sine, Q14, quarter wave polynomial folded by quadrant
    function automatic longint quarter_sin(longint z);
        longint z2, v;
        z2 = (z * z) >>> 14;
        v  = (z2 * (POLY_C5 - ((POLY_C3 * z2) >>> 14))) >>> 14;
        return (z * (POLY_PI - v)) >>> 15;
    endfunction

    function automatic longint sin_q14(logic [15:0] a);
        longint p, s;
        p = longint'(a[13:0]);
        s = a[14] ? quarter_sin(Q14_ONE - p) : quarter_sin(p);
        return a[15] ? -s : s;
    endfunction

    function automatic longint map_cell(longint rot, longint pose, longint org);
        longint q8;
        q8 = rot / (longint'(1) << 20) + (pose - org) * 256;
        return (q8 * longint'(cfg_scale)) / (longint'(1) << 28);
    endfunction

    function automatic bit cell_hit(longint idx);
        longint size;
        size = longint'(cfg_w) * longint'(cfg_h);
        if (idx < 0 || idx >= size || idx >= MAP_CELLS) return 1'b0;
        return occ_map[idx];
    endfunction

    // Update the predictor for one accepted beat; returns 1 with a result
    function automatic bit filter_beam(t_beam_item it, output t_beam_result res);
        logic [15:0] ang;
        longint sb, cb, px, py, rx, ry, ix, iy, flat, k;
        bit hit;
        case (it.action)
            ACT_CELL: begin
                occ_map[it.cell_index] = (it.cell_value == OCC_VALUE);
                return 1'b0;
            end
            ACT_SCAN: begin
                scan_x   = it.pose_x_mm;
                scan_y   = it.pose_y_mm;
                scan_c   = it.pose_cos;
                scan_s   = it.pose_sin;
                scan_a0  = it.angle_start;
                scan_da  = it.angle_step;
                beam_cnt = '0;
                return 1'b0;
            end
            ACT_BEAM: begin
                hit = 1'b0;
                if (it.range_mm > cfg_max_range) begin
                    hit = 1'b1;
                end else begin
                    ang  = scan_a0 + beam_cnt * scan_da;
                    sb   = sin_q14(ang);
                    cb   = sin_q14(ang + 16'd16384);
                    px   = longint'(it.range_mm) * cb;
                    py   = longint'(it.range_mm) * sb;
                    rx   = longint'(scan_c) * px - longint'(scan_s) * py;
                    ry   = longint'(scan_s) * px + longint'(scan_c) * py;
                    ix   = map_cell(rx, scan_x, cfg_org_x);
                    iy   = map_cell(ry, scan_y, cfg_org_y);
                    flat = ix + iy * longint'(cfg_w);
                    k    = (cfg_offset > MAX_OFFSET) ? MAX_OFFSET : cfg_offset;
                    for (longint dy = -k; dy <= k && !hit; dy++)
                        for (longint dx = -k; dx <= k && !hit; dx++)
                            if (cell_hit(flat + dx + dy * longint'(cfg_w))) hit = 1'b1;
                end
                res.range_mm = hit ? 16'd0 : it.range_mm;
                res.removed  = hit;
                res.beam     = beam_cnt;
                beam_cnt     = beam_cnt + 12'd1;
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    task automatic report(string what, int got, int exp);
        $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, exp, cycles);
        errors++;
    endtask

    // Result checker: each accepted result beat against the oldest expectation
    always @(posedge i_clk) begin
        t_beam_result e;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (pending_results.size() == 0) begin
                report("unexpected result beat", out_if.beam_number, -1);
            end else begin
                e = pending_results.pop_front();
                if (out_if.filtered_range_mm !== e.range_mm)
                    report("filtered_range_mm", out_if.filtered_range_mm, e.range_mm);
                if (out_if.removed !== e.removed)
                    report("removed", out_if.removed, e.removed);
                if (out_if.beam_number !== e.beam)
                    report("beam_number", out_if.beam_number, e.beam);
            end
        end
    end

    // Receiver: changing stall pattern, plus long hold-offs on request
    always @(negedge i_clk) begin
        if (hold_req > 0) begin
            hold_req--;
            out_if.ready = 1'b0;
        end else begin
            case ((cycles / 97) % 4)
                0:       out_if.ready = 1'b1;
                1:       out_if.ready = ($urandom_range(0, 1) == 1);
                2:       out_if.ready = ($urandom_range(0, 3) != 0);
                default: out_if.ready = ($urandom_range(0, 5) == 0);
            endcase
        end
    end

    // Send one beat; bursts of random length separated by random gaps unless no_gaps is set
    task automatic send_beat(t_beam_item it);
        t_beam_result r;
        if (!no_gaps && burst_left == 0) begin
            in_if.valid = 1'b0;
            repeat ($urandom_range(0, 8)) @(negedge i_clk);
            burst_left = $urandom_range(1, 24);
        end
        if (burst_left > 0) burst_left--;
        in_if.valid       = 1'b1;
        in_if.action      = it.action;
        in_if.cell_index  = it.cell_index;
        in_if.cell_value  = it.cell_value;
        in_if.range_mm    = it.range_mm;
        in_if.pose_x_mm   = it.pose_x_mm;
        in_if.pose_y_mm   = it.pose_y_mm;
        in_if.pose_cos    = it.pose_cos;
        in_if.pose_sin    = it.pose_sin;
        in_if.angle_start = it.angle_start;
        in_if.angle_step  = it.angle_step;
        do @(posedge i_clk); while (!in_if.ready);
        if (filter_beam(it, r)) pending_results.push_back(r);
        @(negedge i_clk);
        in_if.valid = 1'b0;
    endtask

    // Wait for the block to go idle, then write one register
    task automatic write_cfg(logic [2:0] idx, logic [23:0] val);
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (32) @(negedge i_clk);
        i_cfg_wr_en = 1'b1;
        i_cfg_index = idx;
        i_cfg_wdata = val;
        case (idx)
            CFG_MAX_RANGE: cfg_max_range = val[15:0];
            CFG_OFFSET:    cfg_offset    = val[3:0];
            CFG_SCALE:     cfg_scale     = val[20:0];
            CFG_ORIGIN_X:  cfg_org_x     = val;
            CFG_ORIGIN_Y:  cfg_org_y     = val;
            CFG_MAP_W:     cfg_w         = val[10:0];
            CFG_MAP_H:     cfg_h         = val[10:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_wr_en = 1'b0;
    endtask

    task automatic set_geometry(logic [20:0] scale, logic [23:0] ox, logic [23:0] oy,
                                logic [10:0] w, logic [10:0] h, logic [3:0] k,
                                logic [15:0] maxr);
        write_cfg(CFG_SCALE, scale);
        write_cfg(CFG_ORIGIN_X, ox);
        write_cfg(CFG_ORIGIN_Y, oy);
        write_cfg(CFG_MAP_W, w);
        write_cfg(CFG_MAP_H, h);
        write_cfg(CFG_OFFSET, k);
        write_cfg(CFG_MAX_RANGE, maxr);
    endtask

    function automatic t_beam_item noise_item();
        t_beam_item it;
        it.action      = $urandom_range(0, 3);
        it.cell_index  = $urandom;
        it.cell_value  = ($urandom_range(0, 2) == 0) ? 8'sd100 : $urandom_range(0, 101) - 1;
        it.range_mm    = $urandom;
        it.pose_x_mm   = $urandom;
        it.pose_y_mm   = $urandom;
        it.pose_cos    = $urandom_range(0, 32768) - 16384;
        it.pose_sin    = $urandom_range(0, 32768) - 16384;
        it.angle_start = $urandom;
        it.angle_step  = $urandom;
        return it;
    endfunction

    function automatic t_beam_item cell_item(int idx, bit occ);
        t_beam_item it;
        it = noise_item();
        it.action     = ACT_CELL;
        it.cell_index = idx;
        it.cell_value = occ ? OCC_VALUE : $urandom_range(0, 100) - 1;
        return it;
    endfunction

    function automatic t_beam_item scan_item(int x, int y, int c, int s, int a0, int da);
        t_beam_item it;
        it = noise_item();
        it.action      = ACT_SCAN;
        it.pose_x_mm   = x;
        it.pose_y_mm   = y;
        it.pose_cos    = c;
        it.pose_sin    = s;
        it.angle_start = a0;
        it.angle_step  = da;
        return it;
    endfunction

    function automatic t_beam_item beam_item(int rng);
        t_beam_item it;
        it = noise_item();
        it.action   = ACT_BEAM;
        it.range_mm = rng;
        return it;
    endfunction

    // Extremes, every action, and the special cases at reset settings
    task automatic test_directed();
        t_beam_item it;
        send_beat(beam_item(0));                       // beam before any scan start
        send_beat(beam_item(5000));
        send_beat(beam_item(5001));                    // just over range
        send_beat(beam_item(16'hFFFF));
        send_beat(cell_item(0, 1));
        send_beat(cell_item(MAP_CELLS - 1, 1));
        send_beat(cell_item(1025, 1));
        send_beat(scan_item(0, 0, 16384, 0, 0, 0));
        send_beat(beam_item(0));                       // sits on cell 0
        send_beat(beam_item(60));
        send_beat(scan_item(-100, -100, -16384, 0, 16384, 16'h8000));
        send_beat(beam_item(3000));
        send_beat(beam_item(3000));
        send_beat(scan_item(51000, 51000, 0, -16384, -32768, 32767));
        send_beat(beam_item(1));
        send_beat(beam_item(4999));
        send_beat(cell_item(0, 0));                    // clear again, non-100 value
        it = cell_item(1025, 0);
        it.cell_value = -1;
        send_beat(it);
        send_beat(cell_item(MAP_CELLS - 1, 0));
        it = noise_item();
        it.action = ACT_UNUSED;                        // unknown action, ignored
        send_beat(it);
        send_beat(scan_item(-8388608, 8388607, 16384, 16384, 0, 1));
        send_beat(beam_item(100));
    endtask

    // Small map around the sensor, dense occupancy, well-formed scans
    task automatic test_local_scans(int n, int kmax);
        int done;
        done = 0;
        while (done < n) begin
            case ($urandom_range(0, 9))
                0, 1, 2: send_beat(cell_item($urandom_range(0, 1023), $urandom_range(0, 1)));
                3:       send_beat(scan_item($urandom_range(400, 1200), $urandom_range(400, 1200),
                                             $urandom_range(0, 32768) - 16384,
                                             $urandom_range(0, 32768) - 16384,
                                             $urandom, $urandom_range(0, 2000) - 1000));
                9:       send_beat(noise_item());
                default: send_beat(beam_item($urandom_range(0, 1000)));
            endcase
            done++;
            if (kmax > 0 && done % 150 == 0) write_cfg(CFG_OFFSET, $urandom_range(0, kmax));
        end
    endtask

    // Full-width random items at assorted settings, extremes among them
    task automatic test_wide_random(int n);
        for (int i = 0; i < n; i++) begin
            if (i % 100 == 0) begin
                case ((i / 100) % 6)
                    0: set_geometry(21'd20972, 24'd0, 24'd0, 11'd1024, 11'd1024, 4'd2, 16'hFFFF);
                    1: set_geometry(21'h1FFFFF, 24'h800000, 24'h7FFFFF, 11'd2047, 11'd2047,
                                    4'd1, 16'd0);
                    2: set_geometry(21'd0, 24'd0, 24'd0, 11'd32, 11'd32, 4'd1, 16'd40000);
                    3: set_geometry(21'd1, 24'h7FFFFF, 24'h800000, 11'd0, 11'd1024, 4'd1,
                                    16'd30000);
                    4: set_geometry(21'd1048576, $urandom, $urandom, 11'd1, 11'd1, 4'd0,
                                    $urandom);
                    default: set_geometry($urandom_range(1, 1048576), $urandom, $urandom,
                                          $urandom_range(1, 1024), 11'd0, 4'd2, $urandom);
                endcase
            end
            send_beat(noise_item());
        end
    endtask

    // Widest neighborhood on the small map; slow, so few beams
    task automatic test_max_offset();
        set_geometry(21'd20972, 24'd0, 24'd0, 11'd32, 11'd32, 4'd15, 16'd5000);
        test_local_scans(40, 0);
    endtask

    // Receiver holds off for a long stretch while beats keep coming
    task automatic test_backpressure();
        set_geometry(21'd20972, 24'd0, 24'd0, 11'd32, 11'd32, 4'd0, 16'd5000);
        no_gaps  = 1'b1;
        hold_req = 3000;
        test_local_scans(150, 0);
        no_gaps  = 1'b0;
    endtask

    initial begin
        errors          = 0;
        cycles          = 0;
        burst_left      = 0;
        no_gaps         = 1'b0;
        hold_req        = 0;
        i_rst_n         = 1'b0;
        i_cfg_wr_en     = 1'b0;
        i_cfg_index     = CFG_MAX_RANGE;
        i_cfg_wdata     = '0;
        in_if.valid     = 1'b0;
        in_if.action    = ACT_CELL;
        in_if.cell_index  = '0;
        in_if.cell_value  = '0;
        in_if.range_mm    = '0;
        in_if.pose_x_mm   = '0;
        in_if.pose_y_mm   = '0;
        in_if.pose_cos    = '0;
        in_if.pose_sin    = '0;
        in_if.angle_start = '0;
        in_if.angle_step  = '0;
        out_if.ready      = 1'b0;
        beam_cnt      = '0;
        scan_x        = '0;
        scan_y        = '0;
        scan_c        = 16'sd16384;
        scan_s        = '0;
        scan_a0       = '0;
        scan_da       = '0;
        cfg_max_range = 16'd5000;
        cfg_offset    = 4'd3;
        cfg_scale     = 21'd20972;
        cfg_org_x     = '0;
        cfg_org_y     = '0;
        cfg_w         = 11'd1024;
        cfg_h         = 11'd1024;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        set_geometry(21'd20972, 24'd0, 24'd0, 11'd32, 11'd32, 4'd1, 16'd5000);
        test_local_scans(1200, 3);
        test_wide_random(600);
        test_max_offset();
        test_backpressure();

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (64) @(posedge i_clk);
        if (errors == 0) begin
            $display("tb_scan_point_map_occupancy_filter_core OK");
        end else begin
            $display("tb_scan_point_map_occupancy_filter_core NOT OK");
        end
        $finish;
    end
endmodule
